FILE: rtl/signed_histogram_percentile_threshold_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed histogram percentile threshold block
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_HISTOGRAM_PERCENTILE_THRESHOLD_ASSERT_SVH
`define SIGNED_HISTOGRAM_PERCENTILE_THRESHOLD_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SHPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SHPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/shpt_pkg.sv
// ----------------------------------------------------------------------------
// shpt_pkg
// Commands, field widths and constants of the signed histogram block.
// ----------------------------------------------------------------------------
package shpt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic RESULT_SUMMARY = 1'b0;
    localparam logic RESULT_BIN     = 1'b1;

    localparam int SAMPLE_W = 13;
    localparam int INDEX_W  = 12;
    localparam int MAG_W    = 12;
    localparam int SENS_W   = 10;

    localparam logic [SENS_W-1:0] SENS_RESET    = 10'd990;
    localparam logic [SENS_W-1:0] PERMILLE_FULL = 10'd1000;

endpackage

FILE: rtl/shpt_if.sv
// ----------------------------------------------------------------------------
// shpt_in_if / shpt_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface shpt_in_if;
    logic                                   valid;
    logic                                   ready;
    shpt_pkg::t_cmd                         command;
    logic signed [shpt_pkg::SAMPLE_W-1:0]   sample_value;
    logic                                   bin_side;
    logic        [shpt_pkg::INDEX_W-1:0]    bin_index;

    modport source (output valid, command, sample_value, bin_side, bin_index, input ready);
    modport sink   (input valid, command, sample_value, bin_side, bin_index, output ready);
endinterface

interface shpt_out_if #(
    parameter int COUNT_BITS = 25
);
    logic                                   valid;
    logic                                   ready;
    logic                                   result_kind;
    logic        [shpt_pkg::MAG_W-1:0]      positive_threshold;
    logic signed [shpt_pkg::SAMPLE_W-1:0]   negative_threshold;
    logic        [COUNT_BITS-1:0]           positive_total;
    logic        [COUNT_BITS-1:0]           negative_total;
    logic        [shpt_pkg::MAG_W-1:0]      positive_max;
    logic        [shpt_pkg::MAG_W-1:0]      negative_max_magnitude;
    logic        [COUNT_BITS-1:0]           bin_count;
    logic        [COUNT_BITS-1:0]           bin_cumulative;

    modport source (output valid, result_kind, positive_threshold, negative_threshold,
                    positive_total, negative_total, positive_max, negative_max_magnitude,
                    bin_count, bin_cumulative, input ready);
    modport sink   (input valid, result_kind, positive_threshold, negative_threshold,
                    positive_total, negative_total, positive_max, negative_max_magnitude,
                    bin_count, bin_cumulative, output ready);
endinterface

FILE: rtl/signed_histogram_percentile_threshold.sv
// ----------------------------------------------------------------------------
// signed_histogram_percentile_threshold
// Usage: i_item carries commands (add sample, finish, read bin, clear);
// o_result carries a summary item after finish and a bin item after read.
// Add and clear give no result item. i_cfg_we/i_cfg_wdata set the
// per-mille sensitivity; write it only while the block is idle.
// Adds take one item per cycle: a bin read issued at accept, incremented
// and written back the next cycle, with the last write forwarded.
// A read bin gives its result from S_RDATA via the output register. A
// finish walks every bin through the bin memory port, one bin a cycle,
// in states S_FPREP, S_SCAN and S_FDONE before its result is loaded.
// Reset and clear run a sweep over every address that zeroes both
// memories; no item is accepted during it, configuration writes still are.
// The result sits in an output register; while the receiver stalls, adds
// keep being accepted, and a read or finish waits at its end for the slot.
// ----------------------------------------------------------------------------
`include "signed_histogram_percentile_threshold_assert.svh"

module signed_histogram_percentile_threshold #(
    parameter int MAGNITUDE_BINS = 4096,
    parameter int COUNT_BITS     = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [shpt_pkg::SENS_W-1:0]       i_cfg_wdata,
    shpt_in_if.sink                           i_item,
    shpt_out_if.source                        o_result
);
    import shpt_pkg::*;

    localparam int AW  = $clog2(MAGNITUDE_BINS);
    localparam int CB  = COUNT_BITS;
    localparam int PW  = CB + SENS_W;
    localparam int IW  = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int CW  = (AW > SAMPLE_W) ? AW : SAMPLE_W;
    localparam logic [AW-1:0] LAST_BIN  = AW'(MAGNITUDE_BINS - 1);
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDATA,
        S_FPREP,
        S_SCAN,
        S_FDONE
    } t_state;

    t_state r_state;

    // Memories: word holds {negative, positive}
    logic [2*CB-1:0] r_bins_mem [MAGNITUDE_BINS];
    logic [2*CB-1:0] r_cum_mem  [MAGNITUDE_BINS];
    logic [2*CB-1:0] r_bins_rd;
    logic [2*CB-1:0] r_cum_rd;

    logic [SENS_W-1:0] r_sens;
    logic [CB-1:0]     r_pos_count;
    logic [CB-1:0]     r_neg_count;
    logic [SAMPLE_W-1:0] r_pos_max;
    logic [SAMPLE_W-1:0] r_neg_max;

    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_rd_addr;
    logic              r_last_wr_v;
    logic [AW-1:0]     r_last_wr_addr;
    logic [2*CB-1:0]   r_last_wr_data;

    logic              r_add_v;
    logic              r_add_neg;
    logic              r_rd_side;
    logic              r_rd_oor;

    logic [AW-1:0]     r_scan_addr;
    logic              r_issue;
    logic              r_s1_v;
    logic              r_s2_v;
    logic [AW-1:0]     r_s2_idx;
    logic              r_s3_v;
    logic [AW-1:0]     r_s3_idx;
    logic [CB-1:0]     r_run_p;
    logic [CB-1:0]     r_run_n;
    logic [PW-1:0]     r_prod_p;
    logic [PW-1:0]     r_prod_n;
    logic [PW-1:0]     r_target_p;
    logic [PW-1:0]     r_target_n;
    logic              r_nz_p;
    logic              r_nz_n;
    logic              r_hit_p;
    logic              r_hit_n;
    logic [AW-1:0]     r_found_p;
    logic [AW-1:0]     r_found_n;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [MAG_W-1:0]  r_out_pthr;
    logic signed [SAMPLE_W-1:0] r_out_nthr;
    logic [CB-1:0]     r_out_ptot;
    logic [CB-1:0]     r_out_ntot;
    logic [MAG_W-1:0]  r_out_pmax;
    logic [MAG_W-1:0]  r_out_nmax;
    logic [CB-1:0]     r_out_cnt;
    logic [CB-1:0]     r_out_cum;

    logic              w_accept;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_neg;
    logic [SAMPLE_W-1:0] w_abs;
    logic [CW-1:0]     w_mag_raw;
    logic [CW-1:0]     w_mag_clamp;
    logic [AW-1:0]     w_mag_addr;
    logic [SAMPLE_W-1:0] w_mag13;
    logic [IW-1:0]     w_idx_ext;
    logic              w_idx_oor;
    logic              w_is_add;

    logic              w_bins_re;
    logic [AW-1:0]     w_bins_raddr;
    logic              w_bins_we;
    logic [AW-1:0]     w_bins_waddr;
    logic [2*CB-1:0]   w_bins_wdata;
    logic              w_cum_re;
    logic              w_cum_we;
    logic [AW-1:0]     w_cum_waddr;
    logic [2*CB-1:0]   w_cum_wdata;

    logic [2*CB-1:0]   w_bins_cur;
    logic [CB-1:0]     w_cur_p;
    logic [CB-1:0]     w_cur_n;
    logic [CB-1:0]     w_inc_p;
    logic [CB-1:0]     w_inc_n;
    logic [CB:0]       w_sum_p;
    logic [CB:0]       w_sum_n;
    logic [CB-1:0]     w_run_p;
    logic [CB-1:0]     w_run_n;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_out_load = w_out_free && ((r_state == S_RDATA) || (r_state == S_FDONE));

    assign i_item.ready = (r_state == S_IDLE);

    // Sample magnitude, clamped to the last bin
    assign w_neg       = i_item.sample_value[SAMPLE_W-1];
    assign w_abs       = w_neg ? (SAMPLE_W'(0) - $unsigned(i_item.sample_value))
                               : $unsigned(i_item.sample_value);
    assign w_mag_raw   = CW'(w_abs);
    assign w_mag_clamp = (w_mag_raw > CW'(LAST_BIN)) ? CW'(LAST_BIN) : w_mag_raw;
    assign w_mag_addr  = w_mag_clamp[AW-1:0];
    assign w_mag13     = SAMPLE_W'(w_mag_clamp);
    assign w_is_add    = (i_item.command == CMD_ADD) && (i_item.sample_value != '0);

    assign w_idx_ext = IW'(i_item.bin_index);
    assign w_idx_oor = w_idx_ext >= IW'(MAGNITUDE_BINS);

    // Forward the newest write when the read raced it
    assign w_bins_cur = (r_last_wr_v && (r_last_wr_addr == r_rd_addr)) ? r_last_wr_data
                                                                         : r_bins_rd;
    assign w_cur_p = w_bins_cur[CB-1:0];
    assign w_cur_n = w_bins_cur[2*CB-1:CB];
    assign w_inc_p = (w_cur_p == COUNT_MAX) ? w_cur_p : w_cur_p + CB'(1);
    assign w_inc_n = (w_cur_n == COUNT_MAX) ? w_cur_n : w_cur_n + CB'(1);

    assign w_sum_p = {1'b0, r_run_p} + {1'b0, w_cur_p};
    assign w_sum_n = {1'b0, r_run_n} + {1'b0, w_cur_n};
    assign w_run_p = w_sum_p[CB] ? COUNT_MAX : w_sum_p[CB-1:0];
    assign w_run_n = w_sum_n[CB] ? COUNT_MAX : w_sum_n[CB-1:0];

    always_comb begin
        w_bins_re    = 1'b0;
        w_bins_raddr = r_scan_addr;
        w_cum_re     = 1'b0;
        if (w_accept && (i_item.command == CMD_READ)) begin
            w_bins_re    = 1'b1;
            w_cum_re     = 1'b1;
            w_bins_raddr = w_idx_ext[AW-1:0];
        end else if (w_accept && w_is_add) begin
            w_bins_re    = 1'b1;
            w_bins_raddr = w_mag_addr;
        end else if ((r_state == S_SCAN) && r_issue) begin
            w_bins_re    = 1'b1;
        end
    end

    always_comb begin
        w_bins_we    = 1'b0;
        w_bins_waddr = r_rd_addr;
        w_bins_wdata = w_bins_cur;
        if (r_state == S_CLEAR) begin
            w_bins_we    = 1'b1;
            w_bins_waddr = r_clr_addr;
            w_bins_wdata = '0;
        end else if (r_add_v) begin
            w_bins_we    = 1'b1;
            w_bins_wdata = r_add_neg ? {w_inc_n, w_cur_p} : {w_cur_n, w_inc_p};
        end
    end

    always_comb begin
        w_cum_we    = 1'b0;
        w_cum_waddr = r_rd_addr;
        w_cum_wdata = {w_run_n, w_run_p};
        if (r_state == S_CLEAR) begin
            w_cum_we    = 1'b1;
            w_cum_waddr = r_clr_addr;
            w_cum_wdata = '0;
        end else if (r_s1_v) begin
            w_cum_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bins_we) begin
            r_bins_mem[w_bins_waddr] <= w_bins_wdata;
        end
        if (w_bins_re) begin
            r_bins_rd <= r_bins_mem[w_bins_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cum_we) begin
            r_cum_mem[w_cum_waddr] <= w_cum_wdata;
        end
        if (w_cum_re) begin
            r_cum_rd <= r_cum_mem[w_bins_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sens      <= SENS_RESET;
            r_clr_addr  <= '0;
            r_last_wr_v <= 1'b0;
            r_add_v     <= 1'b0;
            r_issue     <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_count <= '0;
            r_neg_count <= '0;
            r_pos_max   <= '0;
            r_neg_max   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sens <= i_cfg_wdata;
            end

            if (w_bins_re) begin
                r_rd_addr <= w_bins_raddr;
            end
            if (w_bins_we) begin
                r_last_wr_v    <= (r_state != S_CLEAR);
                r_last_wr_addr <= w_bins_waddr;
                r_last_wr_data <= w_bins_wdata;
            end

            r_add_v <= w_accept && w_is_add;

            // Scan pipeline: read, accumulate, scale, compare
            r_s1_v   <= (r_state == S_SCAN) && r_issue;
            r_s2_v   <= r_s1_v;
            r_s2_idx <= r_rd_addr;
            r_s3_v   <= r_s2_v;
            r_s3_idx <= r_s2_idx;
            if (r_s1_v) begin
                r_run_p <= w_run_p;
                r_run_n <= w_run_n;
            end
            r_prod_p <= PW'(r_run_p) * PW'(PERMILLE_FULL);
            r_prod_n <= PW'(r_run_n) * PW'(PERMILLE_FULL);
            if (r_s3_v && (r_s3_idx != '0)) begin
                if (!r_hit_p && r_nz_p && (r_prod_p >= r_target_p)) begin
                    r_hit_p   <= 1'b1;
                    r_found_p <= r_s3_idx;
                end
                if (!r_hit_n && r_nz_n && (r_prod_n >= r_target_n)) begin
                    r_hit_n   <= 1'b1;
                    r_found_n <= r_s3_idx;
                end
            end

            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_pos_count <= '0;
                    r_neg_count <= '0;
                    r_pos_max   <= '0;
                    r_neg_max   <= '0;
                    r_clr_addr  <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_BIN) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_item.command)
                            CMD_ADD: begin
                                r_add_neg <= w_neg;
                                if (w_is_add && w_neg) begin
                                    r_neg_count <= (r_neg_count == COUNT_MAX)
                                                   ? r_neg_count : r_neg_count + CB'(1);
                                    if (w_mag13 > r_neg_max) begin
                                        r_neg_max <= w_mag13;
                                    end
                                end else if (w_is_add) begin
                                    r_pos_count <= (r_pos_count == COUNT_MAX)
                                                   ? r_pos_count : r_pos_count + CB'(1);
                                    if (w_mag13 > r_pos_max) begin
                                        r_pos_max <= w_mag13;
                                    end
                                end
                            end
                            CMD_FINISH: begin
                                r_state <= S_FPREP;
                            end
                            CMD_READ: begin
                                r_rd_side <= i_item.bin_side;
                                r_rd_oor  <= w_idx_oor;
                                r_state   <= S_RDATA;
                            end
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RDATA: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= RESULT_BIN;
                        r_out_pthr  <= '0;
                        r_out_nthr  <= '0;
                        r_out_ptot  <= r_pos_count;
                        r_out_ntot  <= r_neg_count;
                        r_out_pmax  <= MAG_W'(r_pos_max);
                        r_out_nmax  <= MAG_W'(r_neg_max);
                        if (r_rd_oor) begin
                            r_out_cnt <= '0;
                            r_out_cum <= '0;
                        end else if (r_rd_side) begin
                            r_out_cnt <= w_cur_n;
                            r_out_cum <= r_cum_rd[2*CB-1:CB];
                        end else begin
                            r_out_cnt <= w_cur_p;
                            r_out_cum <= r_cum_rd[CB-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FPREP: begin
                    r_target_p  <= PW'(r_sens) * PW'(r_pos_count);
                    r_target_n  <= PW'(r_sens) * PW'(r_neg_count);
                    r_nz_p      <= (r_pos_count != '0);
                    r_nz_n      <= (r_neg_count != '0);
                    r_hit_p     <= 1'b0;
                    r_hit_n     <= 1'b0;
                    r_found_p   <= '0;
                    r_found_n   <= '0;
                    r_run_p     <= '0;
                    r_run_n     <= '0;
                    r_scan_addr <= '0;
                    r_issue     <= 1'b1;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_issue) begin
                        r_scan_addr <= r_scan_addr + AW'(1);
                        if (r_scan_addr == LAST_BIN) begin
                            r_issue <= 1'b0;
                        end
                    end
                    // last bin leaves the compare stage at this edge
                    if (r_s3_v && (r_s3_idx == LAST_BIN)) begin
                        r_state <= S_FDONE;
                    end
                end
                S_FDONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= RESULT_SUMMARY;
                        r_out_pthr  <= MAG_W'(r_found_p);
                        r_out_nthr  <= $signed(SAMPLE_W'(0) - SAMPLE_W'(r_found_n));
                        r_out_ptot  <= r_pos_count;
                        r_out_ntot  <= r_neg_count;
                        r_out_pmax  <= MAG_W'(r_pos_max);
                        r_out_nmax  <= MAG_W'(r_neg_max);
                        r_out_cnt   <= '0;
                        r_out_cum   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid                  = r_out_valid;
    assign o_result.result_kind            = r_out_kind;
    assign o_result.positive_threshold     = r_out_pthr;
    assign o_result.negative_threshold     = r_out_nthr;
    assign o_result.positive_total         = r_out_ptot;
    assign o_result.negative_total         = r_out_ntot;
    assign o_result.positive_max           = r_out_pmax;
    assign o_result.negative_max_magnitude = r_out_nmax;
    assign o_result.bin_count              = r_out_cnt;
    assign o_result.bin_cumulative         = r_out_cum;

    `SHPT_ASSERT_SAME(a_bins_port_single_user, i_clk, i_rst_n, r_add_v, !r_s1_v,
        "add write-back and scan accumulate share the bin read data")
    `SHPT_ASSERT_SAME(a_load_only_at_end, i_clk, i_rst_n, w_out_load,
        (r_state == S_RDATA) || (r_state == S_FDONE),
        "result register loaded outside a read or finish end")
    `SHPT_ASSERT_NEXT(a_found_not_bin_zero, i_clk, i_rst_n, r_state == S_FDONE,
        (r_found_p != '0 || !r_hit_p) && (r_found_n != '0 || !r_hit_n),
        "threshold search hit bin zero")
    `SHPT_ASSERT_SAME(a_no_scan_during_clear, i_clk, i_rst_n, r_state == S_CLEAR,
        !r_s1_v && !r_add_v && !r_issue,
        "memory traffic during clearing sweep")

endmodule
